@@ design/npc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants
// Sizes, register indexes and helpers for the non-overlapping pattern counter.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PAT_BYTES   = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int SKIP_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CMP_W       = (LEN_W > 5) ? LEN_W : 5;
  localparam int CFG_W       = 64;
  localparam int COUNT_W     = 32;

  typedef logic [7:0]         byte_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [SKIP_W-1:0]  skip_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic shift_en;
    logic active;
  } cell_ctrl_t;

  // Returns pattern byte k; bytes beyond the pattern registers read as zero.
  function automatic byte_t pattern_byte(logic [8*PAT_BYTES-1:0] pat, len_t k);
    byte_t res;
    res = '0;
    for (int j = 0; j < PAT_BYTES; j++) begin
      if (int'(k) == j) begin
        res = pat[j*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

@@ design/npc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_cell: one window position
// Holds one text byte, hands it to the next cell on every accepted byte and
// compares the byte entering it against its pattern byte; an inactive cell always reports a hit.
// ----------------------------------------------------------------------------
module npc_cell (
  input  logic                clk,
  input  npc_pkg::cell_ctrl_t ctrl,
  input  npc_pkg::byte_t      byte_in,
  input  npc_pkg::byte_t      target,
  output npc_pkg::byte_t      byte_out,
  output logic                hit
);
  import npc_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = ctrl.shift_en ? byte_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  assign hit      = !ctrl.active || (byte_in == target);

endmodule

@@ design/nonoverlapping_pattern_counter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonoverlapping_pattern_counter_unit: streaming pattern counter
// Counts leftmost non-overlapping occurrences of a configured byte pattern
// in a text stream, using a chain of byte cells that compare in parallel.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while the input is not stalled.
// The count is registered and appears on the output in the cycle after the last byte is accepted.
// The output register lets bytes without the last mark flow while a count
// waits; a last byte waits only while the previous count is still held.
// Reset is synchronous and active low; it clears the text state and sets
// the pattern registers to zero and the length to one.

module nonoverlapping_pattern_counter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  npc_pkg::byte_t                  in_data_byte,
  input  logic                            in_is_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output npc_pkg::count_t                 out_match_count,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [npc_pkg::CFG_W-1:0]       cfg_wdata
);
  import npc_pkg::*;

  logic [63:0] pat_low_r;
  logic [63:0] pat_high_r;
  logic [4:0]  pat_len_r;

  len_t                    seen_r, seen_nxt, seen_inc;
  skip_t                   skip_r, skip_nxt;
  count_t                  count_r, count_nxt, count_step;
  logic                    out_valid_r, out_valid_nxt;
  count_t                  out_count_r, out_count_nxt;
  len_t                    len;
  logic [CMP_W-1:0]        len_raw;
  logic                    accept;
  logic                    window_hit;
  logic [MAX_PATTERN-1:0]  hits;
  byte_t                   chain [MAX_PATTERN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r  <= cfg_wdata[63:0];
        REG_PATTERN_HIGH:   pat_high_r <= cfg_wdata[63:0];
        REG_PATTERN_LENGTH: pat_len_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_raw = CMP_W'(pat_len_r);
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end else if (len_raw > CMP_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(len_raw);
    end
  end

  assign in_stall = out_valid_r && out_stall && in_is_last;
  assign accept   = in_valid && !in_stall;
  assign chain[0] = in_data_byte;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    byte_t      target;
    assign ctrl.shift_en = accept;
    assign ctrl.active   = LEN_W'(i) < len;
    assign target        = pattern_byte({pat_high_r, pat_low_r}, len - LEN_W'(i) - LEN_W'(1));
    npc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (chain[i]),
      .target   (target),
      .byte_out (chain[i+1]),
      .hit      (hits[i])
    );
  end

  assign window_hit = &hits;

  always_comb begin
    seen_inc   = (seen_r == LEN_W'(MAX_PATTERN)) ? seen_r : seen_r + LEN_W'(1);
    count_step = (count_r == '1) ? count_r : count_r + COUNT_W'(1);
    seen_nxt   = seen_r;
    skip_nxt   = skip_r;
    count_nxt  = count_r;
    if (accept) begin
      seen_nxt = seen_inc;
      if (skip_r != '0) begin
        skip_nxt = skip_r - SKIP_W'(1);
      end else if (seen_inc >= len && window_hit) begin
        count_nxt = count_step;
        skip_nxt  = SKIP_W'(len - LEN_W'(1));
      end
    end
  end

  always_comb begin
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && in_is_last) begin
      out_count_nxt = count_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      skip_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (accept && in_is_last) begin
      seen_r      <= '0;
      skip_r      <= '0;
      count_r     <= '0;
      out_valid_r <= out_valid_nxt;
    end else begin
      seen_r      <= seen_nxt;
      skip_r      <= skip_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;

  a_skip_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) |-> (seen_r != '0))
    else $error("skip pending with no bytes seen");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_is_last) |=> out_valid_r)
    else $error("last byte did not produce a result");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_is_last) |=> (count_r == '0 && seen_r == '0 && skip_r == '0))
    else $error("text state not cleared after last byte");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_is_last) |=> (count_r >= $past(count_r)))
    else $error("running count decreased mid-text");

endmodule

@@ bench/tb_nonoverlapping_pattern_counter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonoverlapping_pattern_counter_unit: self-checking bench for the counter
// Streams texts through the block under several pattern settings and random
// idling on both channels. A scoreboard predicts the count of each text and
// compares it with every count the block returns.
// ----------------------------------------------------------------------------

module tb_nonoverlapping_pattern_counter_unit;
  import npc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE       = 4;
  localparam int PHASE_BYTES  = 284;
  localparam int MIN_TEXTS    = 48;

  class pattern_match_tracker;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    byte_t       window [MAX_PATTERN];
    int          seen;
    int          skip;
    count_t      running;
    count_t      pending_counts [$];
    int          errors;
    int          texts_done;

    function new();
      pat_lo     = '0;
      pat_hi     = '0;
      pat_len    = 5'd1;
      errors     = 0;
      texts_done = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = '0;
      seen    = 0;
      skip    = 0;
      running = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LOW:    pat_lo  = value;
        REG_PATTERN_HIGH:   pat_hi  = value;
        REG_PATTERN_LENGTH: pat_len = value[4:0];
        default: ;
      endcase
    endfunction

    function int used_len();
      int n;
      n = pat_len;
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
    endfunction

    function byte_t pat_at(int k);
      if (k < 8) return pat_lo[8*k +: 8];
      if (k < 16) return pat_hi[8*(k-8) +: 8];
      return '0;
    endfunction

    function bit window_hit(int n);
      for (int k = 0; k < n; k++) begin
        if (window[n-1-k] != pat_at(k)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(byte_t data, logic last);
      int n;
      n = used_len();
      for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = data;
      if (seen < MAX_PATTERN) seen++;
      if (skip > 0) begin
        skip--;
      end else if (seen >= n && window_hit(n)) begin
        if (running != '1) running++;
        skip = n - 1;
      end
      if (last) begin
        pending_counts.push_back(running);
        texts_done++;
        clear_text();
      end
    endfunction

    function void check_count(count_t got);
      count_t want;
      if (pending_counts.size() == 0) begin
        errors++;
        $display("%0t: unexpected match count, expected none, actual %0d", $time, got);
        return;
      end
      want = pending_counts.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: match count mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n           = 1'b0;
  logic            in_valid        = 1'b0;
  logic            in_stall;
  byte_t           in_data_byte    = '0;
  logic            in_is_last      = 1'b0;
  logic            out_valid;
  logic            out_stall       = 1'b0;
  count_t          out_match_count;
  logic            cfg_we          = 1'b0;
  logic [1:0]      cfg_index       = '0;
  logic [CFG_W-1:0] cfg_wdata      = '0;

  pattern_match_tracker sb = new();

  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    hold_asks   = 0;
  int    hold_seen   = 0;
  int    hold_left   = 0;
  int    bytes_sent  = 0;
  int    cycle_count = 0;
  byte_t cur_pat [16];
  byte_t letter_a;
  byte_t letter_b;
  bit    two_letter  = 1'b0;

  nonoverlapping_pattern_counter_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_count (out_match_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_count(out_match_count);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic push_byte(byte_t data, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(data, last);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_counts.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_pattern(logic [4:0] len_field, bit letters);
    logic [63:0] lo;
    logic [63:0] hi;
    letter_a   = byte_t'($urandom_range(255));
    letter_b   = byte_t'($urandom_range(255));
    two_letter = letters;
    for (int k = 0; k < 16; k++) begin
      if (letters) cur_pat[k] = $urandom_range(1) ? letter_a : letter_b;
      else cur_pat[k] = byte_t'($urandom_range(255));
    end
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = cur_pat[k];
      hi[8*k +: 8] = cur_pat[k+8];
    end
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, {59'd0, len_field});
  endtask

  task automatic send_text(int n_bytes);
    byte_t text [$];
    int    r;
    int    cut;
    int    n;
    n = sb.used_len();
    while (text.size() < n_bytes) begin
      r = $urandom_range(99);
      if (r < 35) begin
        for (int k = 0; k < n; k++) text.push_back(cur_pat[k]);
      end else if (r < 45) begin
        cut = $urandom_range(n - 1);
        for (int k = 0; k < cut; k++) text.push_back(cur_pat[k]);
      end else if (two_letter) begin
        text.push_back($urandom_range(1) ? letter_a : letter_b);
      end else begin
        text.push_back(byte_t'($urandom_range(255)));
      end
    end
    foreach (text[i]) begin
      if (i < text.size() - 1 && $urandom_range(99) < 2) begin
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(31)));
      end
      push_byte(text[i], i == text.size() - 1);
    end
  endtask

  function automatic logic [4:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 5'd0;
    if (r < 16) return 5'($urandom_range(31, 17));
    if (r < 28) return 5'd16;
    if (r < 40) return 5'd1;
    return 5'($urandom_range(15, 2));
  endfunction

  task automatic squeeze_output();
    int saved_idle;
    saved_idle  = tx_idle_pct;
    tx_idle_pct = 0;
    hold_asks++;
    for (int k = 0; k < 12; k++) push_byte(byte_t'($urandom_range(255)), 1'b1);
    tx_idle_pct = saved_idle;
    wait_idle();
  endtask

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    tx_pct = '{13, 65, 0};
    rx_pct = '{65, 13, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the pattern is a single zero byte.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // A length of zero behaves as a length of one.
    write_reg(REG_PATTERN_LOW, 64'h00000000000000FF);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // An overlong length is clipped to the full pattern; a short text gives zero.
    write_reg(REG_PATTERN_LOW, {8{8'h5A}});
    write_reg(REG_PATTERN_HIGH, {8{8'h5A}});
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    push_byte(8'h5A, 1'b1);
    for (int k = 0; k < 16; k++) push_byte(8'h5A, k == 15);
    wait_idle();

    // A length change in the middle of a text leaves the running skip alone.
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    push_byte(8'h5A, 1'b1);
    wait_idle();

    program_pattern(pick_length(), $urandom_range(1));
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      squeeze_output();
      while (bytes_sent < (ph + 1) * PHASE_BYTES ||
             (ph == 2 && sb.texts_done < MIN_TEXTS)) begin
        if ($urandom_range(99) < 30) begin
          wait_idle();
          program_pattern(pick_length(), $urandom_range(1));
        end
        if ($urandom_range(9) == 0) send_text($urandom_range(48, 21));
        else send_text($urandom_range(20, 1));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
